>>> sv/nv21_pkg.sv
// ----------------------------------------------------------------------------
// nv21_pkg
// shared types, constants and helpers of the nv21 to rgba converter
// ----------------------------------------------------------------------------
package nv21_pkg;

    // frame size defaults
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    // field widths
    localparam int SAMPLE_W   = 8;
    localparam int COORD_W    = 12;
    localparam int CFG_SIZE_W = 13;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // lanes, one per luma sample of a 2x2 block
    localparam int LANES     = 4;
    localparam int PIX_IDX_W = $clog2(LANES);
    localparam logic [PIX_IDX_W-1:0] LAST_PIX = PIX_IDX_W'(LANES - 1);

    // bt.601 video range coefficients, 16-bit fraction
    localparam int COEF_W = 19;
    localparam int PROD_W = 28;
    localparam int FRAC_W = 16;
    localparam logic signed [COEF_W-1:0] K_Y  = 19'sd76309;
    localparam logic signed [COEF_W-1:0] K_RV = 19'sd104597;
    localparam logic signed [COEF_W-1:0] K_GU = 19'sd25675;
    localparam logic signed [COEF_W-1:0] K_GV = 19'sd53279;
    localparam logic signed [COEF_W-1:0] K_BU = 19'sd132201;
    localparam logic signed [SAMPLE_W:0] Y_OFS = 9'sd16;
    localparam logic [SAMPLE_W-1:0] C_FLIP = 8'h80;
    localparam logic [SAMPLE_W-1:0] PIX_MAX = 8'd255;

    // register reset values
    localparam logic [CFG_SIZE_W-1:0] WIDTH_RST  = 13'd640;
    localparam logic [CFG_SIZE_W-1:0] HEIGHT_RST = 13'd480;

    // register map, index = byte address / 4
    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_MIRROR       = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] luma_top_left;
        logic [SAMPLE_W-1:0] luma_top_right;
        logic [SAMPLE_W-1:0] luma_bottom_left;
        logic [SAMPLE_W-1:0] luma_bottom_right;
        logic [SAMPLE_W-1:0] chroma_v;
        logic [SAMPLE_W-1:0] chroma_u;
    } blk_item_t;

    typedef struct packed {
        logic [COORD_W-1:0]  pixel_col;
        logic [COORD_W-1:0]  pixel_row;
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
        logic                block_last;
        logic                frame_last;
    } pixel_item_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] cr_r;
        logic signed [PROD_W-1:0] g_u;
        logic signed [PROD_W-1:0] g_v;
        logic signed [PROD_W-1:0] cb_b;
    } chroma_terms_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [COORD_W-1:0] col_left;
        logic [COORD_W-1:0] col_right;
        logic [COORD_W-1:0] row_top;
        logic [COORD_W-1:0] row_bot;
        logic               frame_last;
    } coord_t;

    typedef struct packed {
        rgb_t [LANES-1:0] lane_rgb;
        coord_t           coord;
    } block_t;

    // lane pipeline loads
    typedef struct packed {
        logic mul;
        logic sum;
    } stage_en_t;

    // floor shift by the fraction, then clamp to 0..255
    function automatic logic [SAMPLE_W-1:0] clamp_px(input logic signed [PROD_W-1:0] s);
        logic [SAMPLE_W-1:0] res;
        if (s[PROD_W-1])
        begin
            res = '0;
        end
        else if (|s[PROD_W-2:FRAC_W+SAMPLE_W])
        begin
            res = PIX_MAX;
        end
        else
        begin
            res = s[FRAC_W+SAMPLE_W-1:FRAC_W];
        end
        return res;
    endfunction

endpackage

>>> sv/nv21_chroma.sv
// ----------------------------------------------------------------------------
// nv21_chroma
// shared chroma products of one block, registered
// ----------------------------------------------------------------------------
module nv21_chroma
    import nv21_pkg::*;
(
    input  logic                clk,
    input  logic                load,
    input  logic [SAMPLE_W-1:0] chroma_v,
    input  logic [SAMPLE_W-1:0] chroma_u,
    output chroma_terms_t       terms
);

    logic signed [SAMPLE_W-1:0] v_s;
    logic signed [SAMPLE_W-1:0] u_s;
    chroma_terms_t              terms_next;
    chroma_terms_t              terms_reg;

    // sample - 128 is the sample with its top bit flipped, read as signed
    assign v_s = $signed(chroma_v ^ C_FLIP);
    assign u_s = $signed(chroma_u ^ C_FLIP);

    always_comb
    begin
        terms_next.cr_r = PROD_W'(v_s) * PROD_W'(K_RV);
        terms_next.g_u  = PROD_W'(u_s) * PROD_W'(K_GU);
        terms_next.g_v  = PROD_W'(v_s) * PROD_W'(K_GV);
        terms_next.cb_b = PROD_W'(u_s) * PROD_W'(K_BU);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            terms_reg <= terms_next;
        end
    end

    assign terms = terms_reg;

endmodule

>>> sv/nv21_lane.sv
// ----------------------------------------------------------------------------
// nv21_lane
// one pixel lane: luma product, then color sums and clamp
// ----------------------------------------------------------------------------
module nv21_lane
    import nv21_pkg::*;
(
    input  logic                clk,
    input  stage_en_t           en,
    input  logic [SAMPLE_W-1:0] luma,
    input  chroma_terms_t       chroma,
    output rgb_t                rgb
);

    logic signed [SAMPLE_W:0]   y_diff;
    logic signed [PROD_W-1:0]   y_prod_next;
    logic signed [PROD_W-1:0]   y_prod_reg;
    logic signed [PROD_W-1:0]   r_sum;
    logic signed [PROD_W-1:0]   g_sum;
    logic signed [PROD_W-1:0]   b_sum;
    rgb_t                       rgb_next;
    rgb_t                       rgb_reg;

    assign y_diff      = $signed({1'b0, luma}) - Y_OFS;
    assign y_prod_next = PROD_W'(y_diff) * PROD_W'(K_Y);

    assign r_sum = y_prod_reg + chroma.cr_r;
    assign g_sum = y_prod_reg - chroma.g_u - chroma.g_v;
    assign b_sum = y_prod_reg + chroma.cb_b;

    always_comb
    begin
        rgb_next.red   = clamp_px(r_sum);
        rgb_next.green = clamp_px(g_sum);
        rgb_next.blue  = clamp_px(b_sum);
    end

    always_ff @(posedge clk)
    begin
        if (en.mul)
        begin
            y_prod_reg <= y_prod_next;
        end
        if (en.sum)
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign rgb = rgb_reg;

endmodule

>>> sv/nv21_serial.sv
// ----------------------------------------------------------------------------
// nv21_serial
// merges the four lane results into a stream of pixels, one per cycle while pixel_stall is low
// ----------------------------------------------------------------------------
module nv21_serial
    import nv21_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        blk_in_valid,
    output logic        blk_in_ready,
    input  block_t      blk_in,
    output logic        pixel_valid,
    input  logic        pixel_stall,
    output pixel_item_t pixel_data
);

    block_t                 blk_reg;
    logic                   blk_valid_reg;
    logic                   blk_valid_next;
    logic [PIX_IDX_W-1:0]   idx_reg;
    logic [PIX_IDX_W-1:0]   idx_next;
    pixel_item_t            out_reg;
    pixel_item_t            out_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   out_load;
    logic                   take;
    logic                   last_pix;

    assign out_load     = blk_valid_reg && (!out_valid_reg || !pixel_stall);
    assign last_pix     = (idx_reg == LAST_PIX);
    assign blk_in_ready = !blk_valid_reg || (last_pix && out_load);
    assign take         = blk_in_valid && blk_in_ready;

    // order: top-left, bottom-left, top-right, bottom-right
    always_comb
    begin
        out_next.pixel_col  = idx_reg[1] ? blk_reg.coord.col_right : blk_reg.coord.col_left;
        out_next.pixel_row  = idx_reg[0] ? blk_reg.coord.row_bot : blk_reg.coord.row_top;
        out_next.red        = blk_reg.lane_rgb[idx_reg].red;
        out_next.green      = blk_reg.lane_rgb[idx_reg].green;
        out_next.blue       = blk_reg.lane_rgb[idx_reg].blue;
        out_next.block_last = last_pix;
        out_next.frame_last = last_pix && blk_reg.coord.frame_last;
    end

    always_comb
    begin
        blk_valid_next = blk_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            idx_next       = idx_reg + 1'b1;
            if (last_pix)
            begin
                blk_valid_next = 1'b0;
            end
        end
        else if (!pixel_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (take)
        begin
            blk_valid_next = 1'b1;
            idx_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            blk_valid_reg <= blk_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            blk_reg <= blk_in;
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign pixel_valid = out_valid_reg;
    assign pixel_data  = out_reg;

endmodule

>>> sv/nv21_to_rgba_converter.sv
// ----------------------------------------------------------------------------
// nv21_to_rgba_converter
// nv21 2x2 block to bt.601 rgb pixel converter with optional mirroring
// ----------------------------------------------------------------------------
// usage:
//  - block channel (blk_valid / blk_stall / blk_data): one transaction per
//    2x2 luma block with its shared v and u samples, in raster block order
//  - pixel channel (pixel_valid / pixel_stall / pixel_data): four pixel
//    transactions per block: top-left, bottom-left, top-right, bottom-right,
//    each with its destination column and row
//  - apb port sets frame_width (0x0), frame_height (0x4), mirror_enable (0x8);
//    write only while the block is idle
//  - path: a block passes the product registers, the sum and clamp
//    registers, the block register of the output stage and then its pixel
//    output register
//  - throughput: set by the output stage that sends the four lane results
//    one pixel per cycle while pixel_stall is low; a new block is taken
//    while the previous one is still being sent
//  - the four lanes compute one pixel each in two registered steps
//    (multiply, then sum and clamp)
//  - reset clears the pipeline, the block column and row pair counters and
//    loads 640x480 without mirroring
//  - a pixel stall holds the output register; the pipeline fills behind it
//    and then blk_stall rises
// ----------------------------------------------------------------------------
module nv21_to_rgba_converter
    import nv21_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // block channel
    input  logic                  blk_valid,
    output logic                  blk_stall,
    input  blk_item_t             blk_data,
    // pixel channel
    output logic                  pixel_valid,
    input  logic                  pixel_stall,
    output pixel_item_t           pixel_data,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // size arithmetic width: holds the register value and the maximum size
    localparam int WSW = ($clog2(MAX_WIDTH + 1) > CFG_SIZE_W) ?
                         $clog2(MAX_WIDTH + 1) : CFG_SIZE_W;
    localparam int HSW = ($clog2(MAX_HEIGHT + 1) > CFG_SIZE_W) ?
                         $clog2(MAX_HEIGHT + 1) : CFG_SIZE_W;
    // counter widths: block index below MAX/2
    localparam int BCW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH / 2) : 1;
    localparam int RPW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT / 2) : 1;

    // ---------------- configuration registers ----------------
    logic [CFG_SIZE_W-1:0] frame_width_reg;
    logic [CFG_SIZE_W-1:0] frame_height_reg;
    logic                  mirror_enable_reg;
    logic                  cfg_write;
    reg_idx_t              cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= WIDTH_RST;
            frame_height_reg  <= HEIGHT_RST;
            mirror_enable_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_FRAME_WIDTH:  frame_width_reg   <= pwdata[CFG_SIZE_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg  <= pwdata[CFG_SIZE_W-1:0];
                REG_MIRROR:       mirror_enable_reg <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_reg);
            REG_MIRROR:       prdata = APB_DATA_W'(mirror_enable_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------- pipeline flow control ----------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic ser_ready;
    logic adv1;
    logic adv2;
    logic accept;

    // a stage moves on when it is empty or its successor takes its content
    assign adv2      = !s2_valid_reg || ser_ready;
    assign adv1      = !s1_valid_reg || adv2;
    assign blk_stall = !adv1;
    assign accept    = blk_valid && !blk_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= blk_valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // ---------------- block position ----------------
    logic [BCW-1:0]  block_column_reg;
    logic [BCW-1:0]  block_column_next;
    logic [RPW-1:0]  row_pair_reg;
    logic [RPW-1:0]  row_pair_next;
    logic [WSW-1:0]  width_even;
    logic [WSW-1:0]  eff_width;
    logic [HSW-1:0]  height_even;
    logic [HSW-1:0]  eff_height;
    logic [WSW-1:0]  blocks;
    logic [HSW-1:0]  pairs;
    logic [WSW-1:0]  bc_cur;
    logic [HSW-1:0]  rp_cur;
    logic            bc_last;
    logic            rp_last;
    logic [WSW-1:0]  col_l;
    logic [WSW-1:0]  col_r;
    logic [HSW-1:0]  row_t;
    coord_t          coord_next;
    coord_t          coord_s1_reg;
    coord_t          coord_s2_reg;

    // effective size: even, at least 2, at most the maximum
    always_comb
    begin
        width_even  = WSW'({frame_width_reg[CFG_SIZE_W-1:1], 1'b0});
        height_even = HSW'({frame_height_reg[CFG_SIZE_W-1:1], 1'b0});
        if (width_even < WSW'(2))
        begin
            eff_width = WSW'(2);
        end
        else if (width_even > WSW'(MAX_WIDTH))
        begin
            eff_width = WSW'(MAX_WIDTH);
        end
        else
        begin
            eff_width = width_even;
        end
        if (height_even < HSW'(2))
        begin
            eff_height = HSW'(2);
        end
        else if (height_even > HSW'(MAX_HEIGHT))
        begin
            eff_height = HSW'(MAX_HEIGHT);
        end
        else
        begin
            eff_height = height_even;
        end
    end

    assign blocks = eff_width >> 1;
    assign pairs  = eff_height >> 1;

    // a counter left outside a shrunk frame restarts at zero
    assign bc_cur  = (WSW'(block_column_reg) >= blocks) ? '0 : WSW'(block_column_reg);
    assign rp_cur  = (HSW'(row_pair_reg) >= pairs) ? '0 : HSW'(row_pair_reg);
    assign bc_last = (bc_cur == blocks - WSW'(1));
    assign rp_last = (rp_cur == pairs - HSW'(1));

    always_comb
    begin
        if (bc_last)
        begin
            block_column_next = '0;
            row_pair_next     = rp_last ? '0 : RPW'(rp_cur + HSW'(1));
        end
        else
        begin
            block_column_next = BCW'(bc_cur + WSW'(1));
            row_pair_next     = RPW'(rp_cur);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_column_reg <= '0;
            row_pair_reg     <= '0;
        end
        else if (accept)
        begin
            block_column_reg <= block_column_next;
            row_pair_reg     <= row_pair_next;
        end
    end

    // destination coordinates, mirrored as c -> width - 1 - c
    always_comb
    begin
        col_l = mirror_enable_reg ? (eff_width - WSW'(1) - (bc_cur << 1))
                                  : (bc_cur << 1);
        col_r = mirror_enable_reg ? (eff_width - WSW'(2) - (bc_cur << 1))
                                  : ((bc_cur << 1) | WSW'(1));
        row_t = rp_cur << 1;
        coord_next.col_left   = col_l[COORD_W-1:0];
        coord_next.col_right  = col_r[COORD_W-1:0];
        coord_next.row_top    = row_t[COORD_W-1:0];
        coord_next.row_bot    = row_t[COORD_W-1:0] | COORD_W'(1);
        coord_next.frame_last = bc_last && rp_last;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            coord_s1_reg <= coord_next;
        end
        if (adv2 && s1_valid_reg)
        begin
            coord_s2_reg <= coord_s1_reg;
        end
    end

    // ---------------- color lanes ----------------
    stage_en_t           lane_en;
    chroma_terms_t       chroma_terms;
    logic [SAMPLE_W-1:0] lane_luma [LANES];
    rgb_t                lane_rgb [LANES];
    block_t              blk_merge;

    assign lane_en.mul = accept;
    assign lane_en.sum = adv2 && s1_valid_reg;

    // lane order follows pixel order
    assign lane_luma[0] = blk_data.luma_top_left;
    assign lane_luma[1] = blk_data.luma_bottom_left;
    assign lane_luma[2] = blk_data.luma_top_right;
    assign lane_luma[3] = blk_data.luma_bottom_right;

    nv21_chroma u_chroma (
        .clk      (clk),
        .load     (accept),
        .chroma_v (blk_data.chroma_v),
        .chroma_u (blk_data.chroma_u),
        .terms    (chroma_terms)
    );

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        nv21_lane u_lane (
            .clk    (clk),
            .en     (lane_en),
            .luma   (lane_luma[i]),
            .chroma (chroma_terms),
            .rgb    (lane_rgb[i])
        );
    end

    // merge the lane results with the block position
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            blk_merge.lane_rgb[k] = lane_rgb[k];
        end
        blk_merge.coord = coord_s2_reg;
    end

    // ---------------- pixel output ----------------
    nv21_serial u_serial (
        .clk          (clk),
        .rst_n        (rst_n),
        .blk_in_valid (s2_valid_reg),
        .blk_in_ready (ser_ready),
        .blk_in       (blk_merge),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel_data   (pixel_data)
    );

    // ---------------- assertions ----------------
    // frame end only on a block end
    a_frame_on_block: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid |-> (!pixel_data.frame_last || pixel_data.block_last))
        else $error("frame_last without block_last");

    // the fourth pixel lies on the odd row of its pair
    a_last_row_odd: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && pixel_data.block_last) |-> pixel_data.pixel_row[0])
        else $error("block end on an even row");

    // an accepted block occupies the first stage
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted block lost");

    // the block side is only held off by full pipeline stages
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        blk_stall |-> (s1_valid_reg && s2_valid_reg))
        else $error("stall with room in the pipeline");

endmodule
